// File: design/ncc_pkg.sv
// Shared types and constants of the normalized cross-correlation block.
package ncc_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int IDX_W       = ADDR_W + 1;
  localparam int CNT_W       = 11;
  localparam int SLOT_W      = 10;
  localparam int COEF_W      = 16;
  localparam int FRAC_BITS   = 15;
  localparam int SUM_W       = SAMPLE_BITS + ADDR_W;
  localparam int NUM_W       = SUM_W + 8;
  localparam int MEAN_W      = SAMPLE_BITS + 8;
  localparam int DEV_W       = MEAN_W + 1;
  localparam int PROD_W      = 2 * DEV_W;
  localparam int SQ_W        = 2 * MEAN_W + ADDR_W;
  localparam int ACC_W       = SQ_W + 2;
  localparam int REM_W       = SQ_W + 4;
  localparam int J_W         = IDX_W + 2;
  localparam int STEP_W      = 7;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(1024);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    opcode;
    logic [SLOT_W-1:0]      slot;
    logic [15:0]            x_sample;
    logic [15:0]            y_sample;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        lag_slot;
    logic signed [COEF_W-1:0] coefficient;
    logic                     degenerate;
  } out_item_t;

  typedef struct packed {
    logic                   en;
    logic [ADDR_W-1:0]      addr;
    logic [SAMPLE_BITS-1:0] x;
    logic [SAMPLE_BITS-1:0] y;
  } store_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_MEAN,
    ST_SXX,
    ST_SYY,
    ST_MULT,
    ST_SQRT,
    ST_CROSS,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

// File: design/ncc_store.sv
// Paired x/y sample stores, one write port, registered reads.
module ncc_store (
  input  logic                               clk,
  input  ncc_pkg::store_wr_t                 wr,
  input  logic [ncc_pkg::ADDR_W-1:0]         rd_addr_x,
  input  logic [ncc_pkg::ADDR_W-1:0]         rd_addr_y,
  output logic [ncc_pkg::SAMPLE_BITS-1:0]    rd_x_r,
  output logic [ncc_pkg::SAMPLE_BITS-1:0]    rd_y_r
);

  logic [ncc_pkg::SAMPLE_BITS-1:0] x_mem [ncc_pkg::MAX_SAMPLES];
  logic [ncc_pkg::SAMPLE_BITS-1:0] y_mem [ncc_pkg::MAX_SAMPLES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      x_mem[wr.addr] <= wr.x;
      y_mem[wr.addr] <= wr.y;
    end
    rd_x_r <= x_mem[rd_addr_x];
    rd_y_r <= y_mem[rd_addr_y];
  end

endmodule

// File: design/ncc_mul.sv
// Shared signed deviation multiplier with registered product.
module ncc_mul (
  input  logic                                clk,
  input  logic signed [ncc_pkg::DEV_W-1:0]    a,
  input  logic signed [ncc_pkg::DEV_W-1:0]    b,
  output logic signed [ncc_pkg::PROD_W-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= ncc_pkg::PROD_W'(a) * ncc_pkg::PROD_W'(b);
  end

endmodule

// File: design/normalized_cross_correlation_top.sv
// Top level: sequencer and datapath of the normalized cross-correlation block.
// Usage:
//   Input channel in_valid/in_ready/in_data carries one request: a load writes
//   a sample pair at a position, a query asks for the coefficient of a lag slot.
//   Result channel out_valid/out_ready/out_data carries one item per query.
//   cfg_we/cfg_wdata writes the window length; write only while idle.
// Sequence:
//   A load is written while idle. A query with current statistics runs the
//   cross pass over n pairs, up to 15 divide steps and a move into the output
//   register, where n is the window length; one sample pair per cycle through
//   the shared multiplier.
//   After a load or a register write the next query first rebuilds the
//   statistics: three passes over n pairs (sums, Sxx, Syy), a 34-step mean
//   divide, a 58-step product and a 58-step square root.
//   The block takes no new request while a query is in work.
// Reset clears the statistics, the window length to 1024 and the result valid
// flag; the sample stores keep their contents until written.
// A stalled receiver holds the result in the output register; loads are still
// taken, and a finished query waits until that register frees up.
module normalized_cross_correlation_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ncc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ncc_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [ncc_pkg::CNT_W-1:0]    cfg_wdata
);

  localparam int IDX_W  = ncc_pkg::IDX_W;
  localparam int ACC_W  = ncc_pkg::ACC_W;
  localparam int SQ_W   = ncc_pkg::SQ_W;
  localparam int REM_W  = ncc_pkg::REM_W;
  localparam int NUM_W  = ncc_pkg::NUM_W;
  localparam int MEAN_W = ncc_pkg::MEAN_W;
  localparam int DEV_W  = ncc_pkg::DEV_W;
  localparam int SUM_W  = ncc_pkg::SUM_W;
  localparam int J_W    = ncc_pkg::J_W;
  localparam int SB     = ncc_pkg::SAMPLE_BITS;

  ncc_pkg::state_t state_r, state_nxt;
  logic                        stats_valid_r, stats_valid_nxt;
  logic [ncc_pkg::CNT_W-1:0]   count_r;
  logic                        out_valid_r, out_valid_nxt;
  ncc_pkg::out_item_t          out_data_r, out_data_nxt;
  ncc_pkg::out_item_t          res_r, res_nxt;

  logic [MEAN_W-1:0]           mean_x_r, mean_x_nxt, mean_y_r, mean_y_nxt;
  logic [SQ_W-1:0]             den_r, den_nxt, sxx_r, sxx_nxt;
  logic signed [ACC_W-1:0]     acc_r, acc_nxt;
  logic [SUM_W-1:0]            sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic                        v_rd_r, v_rd_nxt, v_dev_r, v_dev_nxt, v_prod_r, v_prod_nxt;
  logic signed [DEV_W-1:0]     dev_a_r, dev_a_nxt, dev_b_r, dev_b_nxt;
  logic [ncc_pkg::STEP_W-1:0]  cnt_r, cnt_nxt;
  logic [NUM_W-1:0]            qx_r, qx_nxt, qy_r, qy_nxt;
  logic [IDX_W-1:0]            rx_r, rx_nxt, ry_r, ry_nxt;
  logic [2*SQ_W-1:0]           prod_r, prod_nxt;
  logic [SQ_W-1:0]             mplr_r, mplr_nxt;
  logic [REM_W-1:0]            rem_r, rem_nxt;
  logic [SQ_W-1:0]             root_r, root_nxt;
  logic [ACC_W-1:0]            drem_r, drem_nxt;
  logic [ncc_pkg::FRAC_BITS-1:0] q_r, q_nxt;
  logic [ncc_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic                        neg_r, neg_nxt;

  logic [IDX_W-1:0]            n_w;
  logic signed [J_W-1:0]       delay_w, j_w;
  logic                        term_ok, in_pass, pass_done, in_acc;
  logic [SB-1:0]               rd_x, rd_y;
  logic signed [DEV_W-1:0]     dx_w, dy_w;
  logic signed [ncc_pkg::PROD_W-1:0] p_w;
  ncc_pkg::store_wr_t          wr_w;
  logic [ncc_pkg::ADDR_W-1:0]  addr_y_w;
  logic [IDX_W:0]              mx_sh, my_sh;
  logic [REM_W-1:0]            rem_sh, trial;
  logic [ACC_W-1:0]            mag_w, dsh;

  assign in_acc = in_valid && in_ready;

  always_comb begin
    if (count_r < IDX_W'(2)) begin
      n_w = IDX_W'(2);
    end else if (count_r > IDX_W'(ncc_pkg::MAX_SAMPLES)) begin
      n_w = IDX_W'(ncc_pkg::MAX_SAMPLES);
    end else begin
      n_w = IDX_W'(count_r);
    end
  end

  assign delay_w = $signed(J_W'(slot_r)) - $signed(J_W'(n_w[IDX_W-1:1]));
  assign j_w     = $signed(J_W'(idx_r)) + delay_w;
  assign in_pass = (state_r == ncc_pkg::ST_SUM) || (state_r == ncc_pkg::ST_SXX) ||
                   (state_r == ncc_pkg::ST_SYY) || (state_r == ncc_pkg::ST_CROSS);
  assign term_ok = (state_r != ncc_pkg::ST_CROSS) ||
                   ((j_w >= $signed(J_W'(0))) && (j_w < $signed(J_W'(n_w))));
  assign pass_done = (idx_r == n_w) && !v_rd_r && !v_dev_r && !v_prod_r;
  assign addr_y_w  = (state_r == ncc_pkg::ST_CROSS) ? j_w[ncc_pkg::ADDR_W-1:0]
                                                    : idx_r[ncc_pkg::ADDR_W-1:0];

  assign wr_w.en   = in_acc && (in_data.opcode == ncc_pkg::OP_LOAD);
  assign wr_w.addr = ncc_pkg::ADDR_W'(in_data.slot);
  assign wr_w.x    = SB'(in_data.x_sample);
  assign wr_w.y    = SB'(in_data.y_sample);

  ncc_store u_store (
    .clk       (clk),
    .wr        (wr_w),
    .rd_addr_x (idx_r[ncc_pkg::ADDR_W-1:0]),
    .rd_addr_y (addr_y_w),
    .rd_x_r    (rd_x),
    .rd_y_r    (rd_y)
  );

  ncc_mul u_mul (
    .clk (clk),
    .a   (dev_a_r),
    .b   (dev_b_r),
    .p_r (p_w)
  );

  assign dx_w = $signed({1'b0, rd_x, 8'b0}) - $signed({1'b0, mean_x_r});
  assign dy_w = $signed({1'b0, rd_y, 8'b0}) - $signed({1'b0, mean_y_r});

  always_comb begin
    state_nxt       = state_r;
    stats_valid_nxt = stats_valid_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    res_nxt         = res_r;
    mean_x_nxt      = mean_x_r;
    mean_y_nxt      = mean_y_r;
    den_nxt         = den_r;
    sxx_nxt         = sxx_r;
    acc_nxt         = acc_r;
    sumx_nxt        = sumx_r;
    sumy_nxt        = sumy_r;
    idx_nxt         = idx_r;
    v_rd_nxt        = 1'b0;
    v_dev_nxt       = v_rd_r && (state_r != ncc_pkg::ST_SUM);
    v_prod_nxt      = v_dev_r;
    dev_a_nxt       = dev_a_r;
    dev_b_nxt       = dev_b_r;
    cnt_nxt         = cnt_r;
    qx_nxt          = qx_r;
    qy_nxt          = qy_r;
    rx_nxt          = rx_r;
    ry_nxt          = ry_r;
    prod_nxt        = prod_r;
    mplr_nxt        = mplr_r;
    rem_nxt         = rem_r;
    root_nxt        = root_r;
    drem_nxt        = drem_r;
    q_nxt           = q_r;
    slot_nxt        = slot_r;
    neg_nxt         = neg_r;
    mx_sh           = {rx_r, qx_r[NUM_W-1]};
    my_sh           = {ry_r, qy_r[NUM_W-1]};
    rem_sh          = {rem_r[REM_W-3:0], prod_r[2*SQ_W-1 -: 2]};
    trial           = REM_W'({root_r, 2'b01});
    mag_w           = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    dsh             = {drem_r[ACC_W-2:0], 1'b0};

    if (in_pass && (idx_r < n_w)) begin
      idx_nxt  = idx_r + IDX_W'(1);
      v_rd_nxt = term_ok;
    end
    if (v_rd_r) begin
      unique case (state_r)
        ncc_pkg::ST_SXX: begin
          dev_a_nxt = dx_w;
          dev_b_nxt = dx_w;
        end
        ncc_pkg::ST_SYY: begin
          dev_a_nxt = dy_w;
          dev_b_nxt = dy_w;
        end
        default: begin
          dev_a_nxt = dx_w;
          dev_b_nxt = dy_w;
        end
      endcase
    end
    if (v_prod_r) begin
      acc_nxt = acc_r + ACC_W'(p_w);
    end

    unique case (state_r)
      ncc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == ncc_pkg::OP_LOAD) begin
            stats_valid_nxt = 1'b0;
          end else begin
            slot_nxt  = in_data.slot;
            idx_nxt   = '0;
            acc_nxt   = '0;
            sumx_nxt  = '0;
            sumy_nxt  = '0;
            state_nxt = stats_valid_r ? ncc_pkg::ST_CROSS : ncc_pkg::ST_SUM;
          end
        end
      end
      ncc_pkg::ST_SUM: begin
        if (v_rd_r) begin
          sumx_nxt = sumx_r + SUM_W'(rd_x);
          sumy_nxt = sumy_r + SUM_W'(rd_y);
        end
        if (pass_done) begin
          qx_nxt    = {sumx_r, 8'b0};
          qy_nxt    = {sumy_r, 8'b0};
          rx_nxt    = '0;
          ry_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ncc_pkg::ST_MEAN;
        end
      end
      ncc_pkg::ST_MEAN: begin
        if (mx_sh >= {1'b0, n_w}) begin
          rx_nxt = IDX_W'(mx_sh - {1'b0, n_w});
          qx_nxt = {qx_r[NUM_W-2:0], 1'b1};
        end else begin
          rx_nxt = IDX_W'(mx_sh);
          qx_nxt = {qx_r[NUM_W-2:0], 1'b0};
        end
        if (my_sh >= {1'b0, n_w}) begin
          ry_nxt = IDX_W'(my_sh - {1'b0, n_w});
          qy_nxt = {qy_r[NUM_W-2:0], 1'b1};
        end else begin
          ry_nxt = IDX_W'(my_sh);
          qy_nxt = {qy_r[NUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + ncc_pkg::STEP_W'(1);
        if (cnt_r == ncc_pkg::STEP_W'(NUM_W - 1)) begin
          mean_x_nxt = qx_nxt[MEAN_W-1:0];
          mean_y_nxt = qy_nxt[MEAN_W-1:0];
          idx_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = ncc_pkg::ST_SXX;
        end
      end
      ncc_pkg::ST_SXX: begin
        if (pass_done) begin
          sxx_nxt   = acc_r[SQ_W-1:0];
          acc_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = ncc_pkg::ST_SYY;
        end
      end
      ncc_pkg::ST_SYY: begin
        if (pass_done) begin
          mplr_nxt  = acc_r[SQ_W-1:0];
          prod_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ncc_pkg::ST_MULT;
        end
      end
      ncc_pkg::ST_MULT: begin
        prod_nxt = {prod_r[2*SQ_W-2:0], 1'b0} +
                   (mplr_r[SQ_W-1] ? (2*SQ_W)'(sxx_r) : '0);
        mplr_nxt = {mplr_r[SQ_W-2:0], 1'b0};
        cnt_nxt  = cnt_r + ncc_pkg::STEP_W'(1);
        if (cnt_r == ncc_pkg::STEP_W'(SQ_W - 1)) begin
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ncc_pkg::ST_SQRT;
        end
      end
      ncc_pkg::ST_SQRT: begin
        if (rem_sh >= trial) begin
          rem_nxt  = rem_sh - trial;
          root_nxt = {root_r[SQ_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh;
          root_nxt = {root_r[SQ_W-2:0], 1'b0};
        end
        prod_nxt = {prod_r[2*SQ_W-3:0], 2'b00};
        cnt_nxt  = cnt_r + ncc_pkg::STEP_W'(1);
        if (cnt_r == ncc_pkg::STEP_W'(SQ_W - 1)) begin
          den_nxt         = root_nxt;
          stats_valid_nxt = 1'b1;
          idx_nxt         = '0;
          acc_nxt         = '0;
          state_nxt       = ncc_pkg::ST_CROSS;
        end
      end
      ncc_pkg::ST_CROSS: begin
        if (pass_done) begin
          res_nxt.lag_slot = slot_r;
          neg_nxt          = acc_r[ACC_W-1];
          if (den_r == '0) begin
            res_nxt.coefficient = '0;
            res_nxt.degenerate  = 1'b1;
            state_nxt           = ncc_pkg::ST_OUT;
          end else if (mag_w >= ACC_W'(den_r)) begin
            res_nxt.coefficient = acc_r[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
            res_nxt.degenerate  = 1'b0;
            state_nxt           = ncc_pkg::ST_OUT;
          end else begin
            drem_nxt  = mag_w;
            q_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = ncc_pkg::ST_DIV;
          end
        end
      end
      ncc_pkg::ST_DIV: begin
        if (dsh >= ACC_W'(den_r)) begin
          drem_nxt = dsh - ACC_W'(den_r);
          q_nxt    = {q_r[ncc_pkg::FRAC_BITS-2:0], 1'b1};
        end else begin
          drem_nxt = dsh;
          q_nxt    = {q_r[ncc_pkg::FRAC_BITS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + ncc_pkg::STEP_W'(1);
        if (cnt_r == ncc_pkg::STEP_W'(ncc_pkg::FRAC_BITS - 1)) begin
          res_nxt.coefficient = neg_r ? -$signed(ncc_pkg::COEF_W'(q_nxt))
                                      : $signed(ncc_pkg::COEF_W'(q_nxt));
          res_nxt.degenerate  = 1'b0;
          state_nxt           = ncc_pkg::ST_OUT;
        end
      end
      ncc_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ncc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ncc_pkg::ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      stats_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ncc_pkg::ST_IDLE;
      stats_valid_r <= 1'b0;
      count_r       <= ncc_pkg::COUNT_RESET;
      out_valid_r   <= 1'b0;
      v_rd_r        <= 1'b0;
      v_dev_r       <= 1'b0;
      v_prod_r      <= 1'b0;
      mean_x_r      <= '0;
      mean_y_r      <= '0;
      den_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      stats_valid_r <= stats_valid_nxt;
      count_r       <= cfg_we ? cfg_wdata : count_r;
      out_valid_r   <= out_valid_nxt;
      v_rd_r        <= v_rd_nxt;
      v_dev_r       <= v_dev_nxt;
      v_prod_r      <= v_prod_nxt;
      mean_x_r      <= mean_x_nxt;
      mean_y_r      <= mean_y_nxt;
      den_r         <= den_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    res_r      <= res_nxt;
    sxx_r      <= sxx_nxt;
    acc_r      <= acc_nxt;
    sumx_r     <= sumx_nxt;
    sumy_r     <= sumy_nxt;
    idx_r      <= idx_nxt;
    dev_a_r    <= dev_a_nxt;
    dev_b_r    <= dev_b_nxt;
    cnt_r      <= cnt_nxt;
    qx_r       <= qx_nxt;
    qy_r       <= qy_nxt;
    rx_r       <= rx_nxt;
    ry_r       <= ry_nxt;
    prod_r     <= prod_nxt;
    mplr_r     <= mplr_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    drem_r     <= drem_nxt;
    q_r        <= q_nxt;
    slot_r     <= slot_nxt;
    neg_r      <= neg_nxt;
  end

  assign in_ready  = (state_r == ncc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.degenerate |-> out_data_r.coefficient == '0)
    else $error("degenerate result with nonzero coefficient");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.opcode == ncc_pkg::OP_LOAD) |=> !stats_valid_r)
    else $error("statistics still valid after load");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ncc_pkg::ST_DIV |-> cnt_r < ncc_pkg::STEP_W'(ncc_pkg::FRAC_BITS))
    else $error("divide step count overrun");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ncc_pkg::ST_OUT && out_valid_r && !out_ready |=> state_r == ncc_pkg::ST_OUT)
    else $error("result left pending stage while output register busy");

endmodule

// File: bench/ncc_checker.sv
// Checker: predicts the correlation result of each query and compares it with the output.
module ncc_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  ncc_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  ncc_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [ncc_pkg::CNT_W-1:0] cfg_wdata,
  output int                        err_count,
  output int                        pending
);

  logic [ncc_pkg::SAMPLE_BITS-1:0] x_mem [ncc_pkg::MAX_SAMPLES];
  logic [ncc_pkg::SAMPLE_BITS-1:0] y_mem [ncc_pkg::MAX_SAMPLES];
  bit                              stats_ok;
  logic [63:0]                     mean_x, mean_y, denom;
  logic [ncc_pkg::CNT_W-1:0]       win_reg;
  ncc_pkg::out_item_t              coef_q[$];
  int                              n_err = 0;

  assign err_count = n_err;

  task automatic report(string what, longint got, longint want);
    $display("ERROR at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    n_err++;
  endtask

  function automatic int win_len();
    int n;
    n = win_reg;
    if (n < 2) n = 2;
    if (n > ncc_pkg::MAX_SAMPLES) n = ncc_pkg::MAX_SAMPLES;
    return n;
  endfunction

  function automatic logic [63:0] dev(logic [ncc_pkg::SAMPLE_BITS-1:0] s, logic [63:0] m);
    return ({48'b0, s} << 8) - m;
  endfunction

  function automatic void rebuild_stats(int n);
    logic [63:0]  sx, sy, sxx, syy, c, d;
    logic [127:0] prod;
    sx = 0; sy = 0; sxx = 0; syy = 0; c = 0;
    for (int i = 0; i < n; i++) begin
      sx += x_mem[i];
      sy += y_mem[i];
    end
    mean_x = (sx << 8) / n;
    mean_y = (sy << 8) / n;
    for (int i = 0; i < n; i++) begin
      d = dev(x_mem[i], mean_x);
      sxx += d * d;
      d = dev(y_mem[i], mean_y);
      syy += d * d;
    end
    prod = {64'b0, sxx} * {64'b0, syy};
    for (int b = 63; b >= 0; b--) begin
      d = c | (64'd1 << b);
      if ({64'b0, d} * {64'b0, d} <= prod) c = d;
    end
    denom = c;
    stats_ok = 1;
  endfunction

  function automatic ncc_pkg::out_item_t corr_at(logic [ncc_pkg::SLOT_W-1:0] slot);
    ncc_pkg::out_item_t r;
    int                 n, lag, j;
    logic [63:0]        acc, mag, rem, q;
    n = win_len();
    if (!stats_ok) rebuild_stats(n);
    lag = int'(slot) - n / 2;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      j = i + lag;
      if (j >= 0 && j < n) acc += dev(x_mem[i], mean_x) * dev(y_mem[j], mean_y);
    end
    r.lag_slot = slot;
    r.degenerate = (denom == 0);
    r.coefficient = '0;
    if (denom != 0) begin
      mag = acc[63] ? -acc : acc;
      if (mag >= denom) begin
        r.coefficient = acc[63] ? 16'sh8000 : 16'sh7fff;
      end else begin
        rem = mag;
        q = 0;
        for (int k = 0; k < ncc_pkg::FRAC_BITS; k++) begin
          rem = rem << 1;
          q = q << 1;
          if (rem >= denom) begin
            rem -= denom;
            q[0] = 1'b1;
          end
        end
        r.coefficient = acc[63] ? -q[15:0] : q[15:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stats_ok = 0;
      mean_x = 0;
      mean_y = 0;
      denom = 0;
      win_reg = ncc_pkg::COUNT_RESET;
      coef_q.delete();
    end else begin
      if (cfg_we) begin
        win_reg = cfg_wdata;
        stats_ok = 0;
      end
      if (in_valid && in_ready) begin
        if (in_data.opcode == ncc_pkg::OP_LOAD) begin
          x_mem[in_data.slot] = in_data.x_sample;
          y_mem[in_data.slot] = in_data.y_sample;
          stats_ok = 0;
        end else begin
          coef_q.insert(coef_q.size(), corr_at(in_data.slot));
        end
      end
      if (out_valid && out_ready) begin
        if (coef_q.size() == 0) begin
          report("unexpected result, lag_slot", out_data.lag_slot, 0);
        end else begin
          if (out_data.lag_slot !== coef_q[0].lag_slot)
            report("lag_slot", out_data.lag_slot, coef_q[0].lag_slot);
          if (out_data.coefficient !== coef_q[0].coefficient)
            report("coefficient", out_data.coefficient, coef_q[0].coefficient);
          if (out_data.degenerate !== coef_q[0].degenerate)
            report("degenerate", out_data.degenerate, coef_q[0].degenerate);
          void'(coef_q.pop_front());
        end
      end
    end
    pending <= coef_q.size();
  end

endmodule

// File: bench/tb_top.sv
// Testbench top: drives loads, queries and window writes, and gives the verdict.
module tb_top;

  localparam int LIMIT = 4000000;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      in_valid = 0;
  logic                      in_ready;
  ncc_pkg::in_item_t         in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  ncc_pkg::out_item_t        out_data;
  logic                      cfg_we = 0;
  logic [ncc_pkg::CNT_W-1:0] cfg_wdata = '0;
  int                        err_count, pending;

  int  cycles = 0;
  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  hold = 0;
  bit  written [ncc_pkg::MAX_SAMPLES];
  int  n_win = ncc_pkg::MAX_SAMPLES;
  int  n_loads = 0, n_queries = 0;
  bit  corr_mode = 0;

  normalized_cross_correlation_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ncc_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send(ncc_pkg::op_t op, int slot, logic [15:0] xs, logic [15:0] ys);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{opcode: op, slot: slot[ncc_pkg::SLOT_W-1:0], x_sample: xs, y_sample: ys};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == ncc_pkg::OP_LOAD) begin
      written[slot] = 1;
      n_loads++;
    end else begin
      n_queries++;
    end
  endtask

  task automatic load(int slot);
    logic [15:0] xs, ys;
    case ($urandom_range(0, 5))
      0: xs = 16'h0000;
      1: xs = 16'hffff;
      default: xs = 16'($urandom);
    endcase
    ys = corr_mode ? xs + 16'($urandom_range(0, 4095)) : 16'($urandom);
    send(ncc_pkg::OP_LOAD, slot, xs, ys);
  endtask

  task automatic query(int slot);
    send(ncc_pkg::OP_QUERY, slot, 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_window(int v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[ncc_pkg::CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    n_win = (v < 2) ? 2 : (v > ncc_pkg::MAX_SAMPLES ? ncc_pkg::MAX_SAMPLES : v);
    for (int i = 0; i < n_win; i++)
      if (!written[i]) load(i);
  endtask

  task automatic random_items(int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: load($urandom_range(0, n_win - 1));
        4:          load($urandom_range(0, ncc_pkg::MAX_SAMPLES - 1));
        5:          query($urandom_range(0, ncc_pkg::MAX_SAMPLES - 1));
        default:    query($urandom_range(0, n_win - 1));
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // constant samples, then full-scale in phase and in antiphase
    set_window(4);
    for (int i = 0; i < 4; i++) send(ncc_pkg::OP_LOAD, i, 16'h1234, 16'h8001);
    query(2);
    for (int i = 0; i < 4; i++)
      send(ncc_pkg::OP_LOAD, i, (i % 2) ? 16'hffff : 16'h0000,
           (i % 2) ? 16'hffff : 16'h0000);
    query(2);
    query(3);
    query(1023);
    for (int i = 0; i < 4; i++)
      send(ncc_pkg::OP_LOAD, i, (i % 2) ? 16'hffff : 16'h0000,
           (i % 2) ? 16'h0000 : 16'hffff);
    query(2);
    query(0);
    set_window(0);
    query(1);
    set_window(1);
    query(0);
    set_window(160);
    query(0);
    query(80);
    query(159);
    query(1023);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      corr_mode = ph[0];
      set_window(($urandom_range(0, 3) == 0) ? $urandom_range(2, 160) : $urandom_range(2, 40));
      random_items(45);
    end

    // long receiver hold while the sender keeps offering
    idle_pct = 0;
    stall_pct = 0;
    set_window(24);
    fork
      begin
        hold <= 1'b1;
        repeat (3000) @(posedge clk);
        hold <= 1'b0;
      end
      begin
        query(12);
        for (int i = 0; i < 6; i++) load($urandom_range(0, 23));
        query(5);
        query(30);
        random_items(20);
      end
    join

    drain();
    $display("Covered %0d loads and %0d queries", n_loads, n_queries);
    $display("Windows of 2 to 160 pairs, stalls on both sides and a long result hold");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
